/* rtl/cstp_pkg.sv */
package cstp_pkg;

	// characters the parser reacts to
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// parser state at the last character of a string
	typedef struct packed {
		logic        hash_done;
		logic        comp_done;
		logic [2:0]  count;
		logic [23:0] acc;
		logic [7:0]  red;
		logic [7:0]  green;
	} snap_t;

	// scale an n-digit hex component to 8 bits, rounded: (v*255 + max/2) / max
	// with max = 2^(4n)-1; division by 2^k-1 is a shift plus one correction
	function automatic logic [7:0] scale8(input logic [15:0] v, input logic [2:0] n);
		logic [19:0] x3;
		logic [7:0]  q3;
		logic [12:0] r3;
		logic [23:0] x4;
		logic [7:0]  q4;
		logic [16:0] r4;
		logic [7:0]  res;
		x3 = ({8'd0, v[11:0]} << 8) - {8'd0, v[11:0]} + 20'd2047;
		q3 = x3[19:12];
		r3 = {1'b0, x3[11:0]} + {5'd0, q3};
		x4 = ({8'd0, v} << 8) - {8'd0, v} + 24'd32767;
		q4 = x4[23:16];
		r4 = {1'b0, x4[15:0]} + {9'd0, q4};
		case (n)
			3'd1: res = {v[3:0], v[3:0]};
			3'd2: res = v[7:0];
			3'd3: res = q3 + {7'd0, (r3 >= 13'd4095)};
			3'd4: res = q4 + {7'd0, (r4 >= 17'd65535)};
			default: res = 8'd0;
		endcase
		return res;
	endfunction

endpackage

/* rtl/cstp_parse.sv */
module cstp_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       char_s1,
	input  logic             last_s1,
	input  logic             move_s1,
	input  logic             move_s2,
	output logic             valid_s2,
	output cstp_pkg::snap_t  snap_s2
);
	import cstp_pkg::*;

	typedef enum logic [2:0] {
		PH_LEAD, PH_HASH, PH_WANT_G, PH_WANT_B, PH_WANT_COLON, PH_COMP, PH_ERR
	} phase_t;

	phase_t      ph_q, ph_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [1:0]  idx_q, idx_d;
	logic [23:0] acc_q, acc_d;
	logic [7:0]  red_q, red_d;
	logic [7:0]  green_q, green_d;
	logic        trail_q, trail_d;
	logic        blank;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [7:0]  comp_scaled;
	snap_t       snap_d;

	// hex digit decode, either case
	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (char_s1 inside {[8'h30:8'h39]}) begin
			hex_val = char_s1[3:0];
		end else if (char_s1 inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			hex_val = char_s1[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign blank       = (char_s1 == CH_SPACE) || (char_s1 == CH_TAB);
	assign comp_scaled = scale8(acc_q[15:0], cnt_q);

	// next parser state for the character in stage 1
	always_comb begin
		ph_d    = ph_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		acc_d   = acc_q;
		red_d   = red_q;
		green_d = green_q;
		trail_d = trail_q;
		if (ph_q != PH_ERR) begin
			if (blank) begin
				if (ph_q != PH_LEAD) begin
					trail_d = 1'b1;
				end
			end else if (trail_q) begin
				ph_d = PH_ERR;
			end else begin
				case (ph_q)
					PH_LEAD: begin
						if (char_s1 == CH_HASH) begin
							ph_d = PH_HASH;
						end else if (char_s1 == CH_R) begin
							ph_d = PH_WANT_G;
						end else begin
							ph_d = PH_ERR;
						end
					end
					PH_HASH: begin
						if (!hex_ok) begin
							ph_d = PH_ERR;
						end else if (cnt_q >= 3'd6) begin
							if (cnt_q != 3'd7) cnt_d = cnt_q + 3'd1;
							ph_d = PH_ERR;
						end else begin
							cnt_d = cnt_q + 3'd1;
							acc_d = {acc_q[19:0], hex_val};
						end
					end
					PH_WANT_G: ph_d = (char_s1 == CH_G) ? PH_WANT_B : PH_ERR;
					PH_WANT_B: ph_d = (char_s1 == CH_B) ? PH_WANT_COLON : PH_ERR;
					PH_WANT_COLON: ph_d = (char_s1 == CH_COLON) ? PH_COMP : PH_ERR;
					PH_COMP: begin
						if (char_s1 == CH_SLASH) begin
							if (idx_q >= 2'd2 || cnt_q == 3'd0 || cnt_q > 3'd4) begin
								ph_d = PH_ERR;
							end else begin
								if (idx_q == 2'd0) begin
									red_d = comp_scaled;
								end else begin
									green_d = comp_scaled;
								end
								idx_d = idx_q + 2'd1;
								cnt_d = 3'd0;
								acc_d = 24'd0;
							end
						end else if (!hex_ok) begin
							ph_d = PH_ERR;
						end else if (cnt_q >= 3'd4) begin
							if (cnt_q != 3'd7) cnt_d = cnt_q + 3'd1;
							ph_d = PH_ERR;
						end else begin
							cnt_d = cnt_q + 3'd1;
							acc_d = {acc_q[19:0], hex_val};
						end
					end
					default: ph_d = PH_ERR;
				endcase
			end
		end
	end

	// snapshot of the state after the last character
	always_comb begin
		snap_d.hash_done = (ph_d == PH_HASH);
		snap_d.comp_done = (ph_d == PH_COMP) && (idx_d == 2'd2);
		snap_d.count     = cnt_d;
		snap_d.acc       = acc_d;
		snap_d.red       = red_d;
		snap_d.green     = green_d;
	end

	// parser state, back to reset after each last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_LEAD;
			cnt_q   <= 3'd0;
			idx_q   <= 2'd0;
			acc_q   <= 24'd0;
			red_q   <= 8'd0;
			green_q <= 8'd0;
			trail_q <= 1'b0;
		end else if (move_s1) begin
			if (last_s1) begin
				ph_q    <= PH_LEAD;
				cnt_q   <= 3'd0;
				idx_q   <= 2'd0;
				acc_q   <= 24'd0;
				red_q   <= 8'd0;
				green_q <= 8'd0;
				trail_q <= 1'b0;
			end else begin
				ph_q    <= ph_d;
				cnt_q   <= cnt_d;
				idx_q   <= idx_d;
				acc_q   <= acc_d;
				red_q   <= red_d;
				green_q <= green_d;
				trail_q <= trail_d;
			end
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (move_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (move_s1 && last_s1) begin
			snap_s2 <= snap_d;
		end
	end

endmodule

/* rtl/cstp_pack.sv */
module cstp_pack (
	input  logic             clk,
	input  logic             arst_n,
	input  cstp_pkg::snap_t  snap_s2,
	input  logic             move_s2,
	input  logic             result_stall,
	output logic             result_valid,
	output logic             parse_ok,
	output logic [23:0]      rgb_value
);
	import cstp_pkg::*;

	logic        ok_d;
	logic [23:0] rgb_d;
	logic [7:0]  blue;

	assign blue = scale8(snap_s2.acc[15:0], snap_s2.count);

	// final check and packing of the color
	always_comb begin
		ok_d  = 1'b0;
		rgb_d = 24'd0;
		if (snap_s2.hash_done) begin
			if (snap_s2.count == 3'd3) begin
				ok_d  = 1'b1;
				rgb_d = {snap_s2.acc[11:8], snap_s2.acc[11:8], snap_s2.acc[7:4],
					snap_s2.acc[7:4], snap_s2.acc[3:0], snap_s2.acc[3:0]};
			end else if (snap_s2.count == 3'd6) begin
				ok_d  = 1'b1;
				rgb_d = snap_s2.acc;
			end
		end else if (snap_s2.comp_done && snap_s2.count >= 3'd1 && snap_s2.count <= 3'd4) begin
			ok_d  = 1'b1;
			rgb_d = {snap_s2.red, snap_s2.green, blue};
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (move_s2) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (move_s2) begin
			parse_ok  <= ok_d;
			rgb_value <= rgb_d;
		end
	end

endmodule

/* rtl/color_spec_text_parser_top.sv */
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+----------------------
// input    | char_valid   | char_stall   | char_code, is_last
// result   | result_valid | result_stall | parse_ok, rgb_value
//
// one character is taken every cycle while no last character is held; the last
// character of a string passes the input, snapshot and output registers to its result
// reset clears the parser state and all valid flags; payload registers are not reset
// only a last character can be held: it waits in the input register while
// the snapshot and output registers are both full and the output is stalled
module color_spec_text_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        is_last,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        parse_ok,
	output logic [23:0] rgb_value
);
	import cstp_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       valid_s2;
	logic       move_s1;
	logic       move_s2;
	logic       out_free;
	logic       s2_free;
	snap_t      snap_s2;

	// stage advance control
	assign out_free   = !result_valid || !result_stall;
	assign move_s2    = valid_s2 && out_free;
	assign s2_free    = !valid_s2 || out_free;
	assign move_s1    = valid_s1 && (!last_s1 || s2_free);
	assign char_stall = valid_s1 && !move_s1;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	cstp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_s1  (char_s1),
		.last_s1  (last_s1),
		.move_s1  (move_s1),
		.move_s2  (move_s2),
		.valid_s2 (valid_s2),
		.snap_s2  (snap_s2)
	);

	cstp_pack u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_s2      (snap_s2),
		.move_s2      (move_s2),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.parse_ok     (parse_ok),
		.rgb_value    (rgb_value)
	);

`ifndef SYNTHESIS
	// an invalid string always reports a zero color
	a_zero_when_bad: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !parse_ok |-> rgb_value == 24'd0)
		else $error("rgb_value not zero on invalid result");

	// only a waiting last character can hold the input
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> valid_s1 && last_s1 && valid_s2 && result_valid && result_stall)
		else $error("input stalled without a full pipe");

	// a snapshot that moves shows up as a result next cycle
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		move_s2 |=> result_valid)
		else $error("result lost after stage 2 transfer");
`endif

endmodule

/* dv/tb_color_spec_text_parser_top.sv */
module tb_color_spec_text_parser_top;
	import cstp_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_CHARS = 820;
	localparam int DRAIN_CYCLES = 8;

	// digit ranges and helpers for building strings
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_LOWER_F  = 8'h66;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_F  = 8'h46;
	localparam logic [7:0] CASE_OFFSET = 8'h20;
	localparam logic [4:0] NOT_HEX     = 5'd16;
	localparam string      RGB_PREFIX  = "rgb:";

	typedef enum logic [3:0] {
		SKIP_LEAD,
		HASH_DIGITS,
		EXPECT_G,
		EXPECT_B,
		EXPECT_COLON,
		RGB_COMPONENTS,
		BAD_SPEC
	} spec_phase_t;

	// kinds of malformed strings
	typedef enum int {
		F_NOISE,
		F_BLANKS,
		F_MUTATE,
		F_INNER_BLANK,
		F_HASH_COUNT,
		F_LONG_COMP,
		F_EMPTY_COMP,
		F_FOURTH_COMP,
		F_SHORT_RGB,
		F_BAD_PREFIX,
		F_TRUNCATE,
		F_TAIL_JUNK,
		F_KINDS
	} flaw_t;

	typedef struct packed {
		logic        ok;
		logic [23:0] rgb;
	} color_result_t;

	// color parser predictor plus queue of colors still owed by the block
	class color_scoreboard;
		spec_phase_t   phase;
		logic [2:0]    ndigits;
		logic [1:0]    comp_idx;
		logic [23:0]   acc;
		logic [7:0]    red8;
		logic [7:0]    green8;
		logic          blank_after_text;
		color_result_t expected_colors[$];
		int            mismatches;
		int            failures;
		int            valid_seen;
		int            invalid_seen;

		function new();
			clear_state();
			mismatches = 0;
			failures = 0;
			valid_seen = 0;
			invalid_seen = 0;
		endfunction

		function void clear_state();
			phase = SKIP_LEAD;
			ndigits = 3'd0;
			comp_idx = 2'd0;
			acc = 24'd0;
			red8 = 8'd0;
			green8 = 8'd0;
			blank_after_text = 1'b0;
		endfunction

		function logic [4:0] hex_digit_value(logic [7:0] c);
			if (c >= CH_ZERO && c <= CH_NINE)
				return 5'(c - CH_ZERO);
			if (c >= CH_LOWER_A && c <= CH_LOWER_F)
				return 5'(c - CH_LOWER_A + 8'd10);
			if (c >= CH_UPPER_A && c <= CH_UPPER_F)
				return 5'(c - CH_UPPER_A + 8'd10);
			return NOT_HEX;
		endfunction

		// (v*255 + max/2) / max with max = 2^(4n)-1
		function logic [7:0] scale_to_8(logic [15:0] v, logic [2:0] n);
			int unsigned top;
			top = (32'd1 << (4 * n)) - 1;
			return 8'((v * 32'd255 + top / 2) / top);
		endfunction

		// one more digit in the current group; overflow saturates and errors
		function void add_digit(logic [3:0] d, int unsigned limit);
			if (ndigits >= limit) begin
				if (ndigits < 3'd7)
					ndigits++;
				phase = BAD_SPEC;
			end else begin
				ndigits++;
				acc = {acc[19:0], d};
			end
		endfunction

		function void parse_char(logic [7:0] c);
			logic       is_blank;
			logic [4:0] d;
			is_blank = (c == CH_SPACE) || (c == CH_TAB);
			d = hex_digit_value(c);
			if (phase == BAD_SPEC)
				return;
			if (is_blank) begin
				if (phase != SKIP_LEAD)
					blank_after_text = 1'b1;
				return;
			end
			if (blank_after_text) begin
				phase = BAD_SPEC;
				return;
			end
			case (phase)
				SKIP_LEAD: begin
					if (c == CH_HASH)
						phase = HASH_DIGITS;
					else if (c == CH_R)
						phase = EXPECT_G;
					else
						phase = BAD_SPEC;
				end
				HASH_DIGITS: begin
					if (d == NOT_HEX)
						phase = BAD_SPEC;
					else
						add_digit(d[3:0], 6);
				end
				EXPECT_G: phase = (c == CH_G) ? EXPECT_B : BAD_SPEC;
				EXPECT_B: phase = (c == CH_B) ? EXPECT_COLON : BAD_SPEC;
				EXPECT_COLON: phase = (c == CH_COLON) ? RGB_COMPONENTS : BAD_SPEC;
				RGB_COMPONENTS: begin
					if (c == CH_SLASH) begin
						if (comp_idx >= 2'd2 || ndigits == 3'd0 || ndigits > 3'd4) begin
							phase = BAD_SPEC;
						end else begin
							if (comp_idx == 2'd0)
								red8 = scale_to_8(acc[15:0], ndigits);
							else
								green8 = scale_to_8(acc[15:0], ndigits);
							comp_idx++;
							ndigits = 3'd0;
							acc = 24'd0;
						end
					end else if (d == NOT_HEX) begin
						phase = BAD_SPEC;
					end else begin
						add_digit(d[3:0], 4);
					end
				end
				default: phase = BAD_SPEC;
			endcase
		endfunction

		// accepted character: advance the parser, owe a color at the last one
		function void note_char(logic [7:0] c, logic last);
			color_result_t res;
			logic [7:0]    r;
			logic [7:0]    g;
			logic [7:0]    b;
			parse_char(c);
			if (!last)
				return;
			res.ok = 1'b0;
			res.rgb = 24'd0;
			if (phase == HASH_DIGITS) begin
				if (ndigits == 3'd3) begin
					r = acc[11:8] * 8'd17;
					g = acc[7:4] * 8'd17;
					b = acc[3:0] * 8'd17;
					res.ok = 1'b1;
					res.rgb = {r, g, b};
				end else if (ndigits == 3'd6) begin
					res.ok = 1'b1;
					res.rgb = acc;
				end
			end else if (phase == RGB_COMPONENTS && comp_idx == 2'd2 &&
					ndigits >= 3'd1 && ndigits <= 3'd4) begin
				res.ok = 1'b1;
				res.rgb = {red8, green8, scale_to_8(acc[15:0], ndigits)};
			end
			if (res.ok)
				valid_seen++;
			else
				invalid_seen++;
			expected_colors.push_back(res);
			clear_state();
		endfunction

		// accepted result against the oldest owed color
		function void check_result(logic ok, logic [23:0] rgb);
			color_result_t want;
			if (expected_colors.size() == 0) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: ok=%0b rgb=%06h", ok, rgb);
				return;
			end
			want = expected_colors.pop_front();
			if (ok !== want.ok || rgb !== want.rgb) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display("color mismatch: expected ok=%0b rgb=%06h, got ok=%0b rgb=%06h",
						want.ok, want.rgb, ok, rgb);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        char_valid;
	logic        char_stall;
	logic [7:0]  char_code;
	logic        is_last;
	logic        result_valid;
	logic        result_stall;
	logic        parse_ok;
	logic [23:0] rgb_value;

	color_scoreboard sb;
	logic [7:0]      spec_chars[$];
	int              tx_idle_pct;
	int              rx_idle_pct;
	int              stall_left;
	int              cycle_count;
	int              chars_sent;
	int              strings_sent;

	color_spec_text_parser_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_code    (char_code),
		.is_last      (is_last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.parse_ok     (parse_ok),
		.rgb_value    (rgb_value)
	);

	// clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// transfers on both channels, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall)
				sb.note_char(char_code, is_last);
			if (result_valid && !result_stall)
				sb.check_result(parse_ok, rgb_value);
		end
	end

	// result side stall bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
			stall_left <= $urandom_range(0, 5);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d colors still owed",
				cycle_count, sb.expected_colors.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// one character transfer, with an optional gap before it
	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			gap = $urandom_range(1, 6);
			char_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_valid <= 1'b1;
		char_code <= c;
		is_last <= last;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		@(negedge clk);
		chars_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < spec_chars.size(); i++)
			send_char(spec_chars[i], i == spec_chars.size() - 1);
		spec_chars.delete();
		strings_sent++;
	endtask

	// sender holds off until every owed color has come back
	task automatic drain_results();
		char_valid <= 1'b0;
		@(negedge clk);
		while (sb.expected_colors.size() != 0)
			@(negedge clk);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			spec_chars.push_back(s[i]);
	endtask

	task automatic push_blanks(input int n);
		repeat (n)
			spec_chars.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endtask

	// random hex digits in mixed case
	task automatic push_hex_digits(input int n);
		logic [7:0] v;
		repeat (n) begin
			v = 8'($urandom_range(0, 15));
			if (v < 8'd10)
				spec_chars.push_back(CH_ZERO + v);
			else
				spec_chars.push_back(($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + v - 8'd10);
		end
	endtask

	// slash separated components; one slot may get an odd digit count
	task automatic push_rgb_body(input int ncomp, input int odd_slot, input int odd_len);
		for (int i = 0; i < ncomp; i++) begin
			if (i != 0)
				spec_chars.push_back(CH_SLASH);
			push_hex_digits(i == odd_slot ? odd_len : $urandom_range(1, 4));
		end
	endtask

	task automatic build_color(input logic pad);
		if (pad)
			push_blanks($urandom_range(0, 2));
		if ($urandom_range(0, 1)) begin
			spec_chars.push_back(CH_HASH);
			push_hex_digits($urandom_range(0, 1) ? 6 : 3);
		end else begin
			push_text(RGB_PREFIX);
			push_rgb_body(3, -1, 0);
		end
		if (pad)
			push_blanks($urandom_range(0, 2));
	endtask

	task automatic build_broken();
		int pos;
		int n;
		case ($urandom_range(0, F_KINDS - 1))
			F_NOISE:
				repeat ($urandom_range(1, 5))
					spec_chars.push_back(8'($urandom_range(0, 255)));
			F_BLANKS: push_blanks($urandom_range(1, 4));
			F_MUTATE: begin
				build_color(1'b1);
				pos = $urandom_range(0, spec_chars.size() - 1);
				spec_chars[pos] = 8'($urandom_range(0, 255));
			end
			F_INNER_BLANK: begin
				build_color(1'b0);
				pos = $urandom_range(1, spec_chars.size() - 1);
				spec_chars.insert(pos, $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
			end
			F_HASH_COUNT: begin
				n = $urandom_range(0, 9);
				if (n == 3 || n == 6)
					n++;
				spec_chars.push_back(CH_HASH);
				push_hex_digits(n);
			end
			F_LONG_COMP: begin
				push_text(RGB_PREFIX);
				push_rgb_body(3, $urandom_range(0, 2), $urandom_range(5, 8));
			end
			F_EMPTY_COMP: begin
				push_text(RGB_PREFIX);
				push_rgb_body(3, $urandom_range(0, 2), 0);
			end
			F_FOURTH_COMP: begin
				push_text(RGB_PREFIX);
				push_rgb_body(4, -1, 0);
			end
			F_SHORT_RGB: begin
				push_text(RGB_PREFIX);
				push_rgb_body($urandom_range(0, 2), -1, 0);
				if ($urandom_range(0, 1))
					spec_chars.push_back(CH_SLASH);
			end
			F_BAD_PREFIX: begin
				push_text(RGB_PREFIX);
				pos = $urandom_range(0, 3);
				if ($urandom_range(0, 1))
					spec_chars[pos] = spec_chars[pos] - CASE_OFFSET;
				else
					spec_chars[pos] = 8'($urandom_range(0, 255));
				push_rgb_body(3, -1, 0);
			end
			F_TRUNCATE: begin
				build_color(1'b0);
				pos = $urandom_range(1, spec_chars.size() - 1);
				while (spec_chars.size() > pos)
					void'(spec_chars.pop_back());
			end
			default: begin
				build_color(1'b1);
				spec_chars.push_back(8'($urandom_range(0, 255)));
			end
		endcase
	endtask

	initial begin
		int  random_start;
		int  random_sent;
		logic paused;
		sb = new();
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_code = 8'd0;
		is_last = 1'b0;
		chars_sent = 0;
		strings_sent = 0;
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: byte extremes, blanks only, both forms, inner blank
		spec_chars.push_back(8'hFF);
		send_text();
		spec_chars.push_back(8'h00);
		send_text();
		spec_chars.push_back(CH_TAB);
		send_text();
		push_text("#FfF");
		send_text();
		push_text(" #0aF9e1");
		send_text();
		push_text("rgb:f/0/1");
		send_text();
		push_text("#1 2");
		send_text();
		drain_results();

		// random strings, mostly well formed, with shifting idle patterns
		random_start = chars_sent;
		random_sent = 0;
		while (random_sent < RANDOM_CHARS) begin
			if (random_sent < 250) begin
				tx_idle_pct = 15;
				rx_idle_pct = 15;
			end else if (random_sent < 450) begin
				tx_idle_pct = 0;
				rx_idle_pct = 35;
			end else if (random_sent < 700) begin
				if (!paused) begin
					paused = 1'b1;
					drain_results();
				end
				tx_idle_pct = 35;
				rx_idle_pct = 5;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if ($urandom_range(0, 99) < 60)
				build_color(1'b1);
			else
				build_broken();
			send_text();
			random_sent = chars_sent - random_start;
		end

		// wait out the pipeline
		char_valid <= 1'b0;
		@(negedge clk);
		while (sb.expected_colors.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("parsed %0d strings from %0d characters: %0d good colors, %0d rejected",
			strings_sent, chars_sent, sb.valid_seen, sb.invalid_seen);
		$display("hash and rgb: forms, blank padding and malformed text under gaps and stalls");
		if (sb.failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
rtl/cstp_pkg.sv
rtl/cstp_parse.sv
rtl/cstp_pack.sv
rtl/color_spec_text_parser_top.sv
dv/tb_color_spec_text_parser_top.sv
